FILE: design/twscs_pkg.sv
// Shared types, command codes and byte classification for the text statistics block.
package twscs_pkg;

	localparam int LETTER_BINS = 26;
	localparam int DIGIT_BINS  = 10;
	localparam int NUM_BINS    = LETTER_BINS + DIGIT_BINS;
	localparam int BIN_W       = 6;
	localparam int OUT_W       = 32;

	localparam logic [1:0] CMD_FEED  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] idx;
	} bin_sel_t;

	function automatic logic is_separator(input logic [7:0] c);
		return (c >= 8'd32 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126) ||
			(c == 8'd10);
	endfunction

	function automatic logic is_sentence_end(input logic [7:0] c);
		return (c == 8'h21) || (c == 8'h2E) || (c == 8'h3F);
	endfunction

	function automatic bin_sel_t bin_of(input logic [7:0] c);
		bin_sel_t r;
		logic [7:0] d;
		r.hit = 1'b0;
		r.idx = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d     = c - 8'h41;
			r.hit = 1'b1;
			r.idx = d[BIN_W-1:0];
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d     = c - 8'h61;
			r.hit = 1'b1;
			r.idx = d[BIN_W-1:0];
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d     = c - 8'h30 + 8'(LETTER_BINS);
			r.hit = 1'b1;
			r.idx = d[BIN_W-1:0];
		end
		return r;
	endfunction

	function automatic bin_sel_t bin_at(input logic [BIN_W-1:0] i);
		bin_sel_t r;
		r.hit = (i < BIN_W'(NUM_BINS));
		r.idx = i;
		return r;
	endfunction

endpackage

FILE: design/twscs_bin_ram.sv
// Histogram bin memory with per-entry valid bits, bulk clear and write forwarding.
module twscs_bin_ram import twscs_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [BIN_W-1:0]       rd_addr,
	input  logic                   wr_en,
	input  logic [BIN_W-1:0]       wr_addr,
	input  logic [COUNT_WIDTH-1:0] wr_data,
	input  logic                   clr,
	output logic [COUNT_WIDTH-1:0] rd_data
);

	logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]    valid_q;
	logic [COUNT_WIDTH-1:0] mem_rd_q;
	logic [BIN_W-1:0]       rd_addr_q;
	logic                   fwd_en_q;
	logic [BIN_W-1:0]       fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			fwd_en_q <= 1'b0;
		end else if (clr) begin
			valid_q  <= '0;
			fwd_en_q <= 1'b0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
			fwd_en_q         <= 1'b1;
		end
	end

	always_comb begin
		if (fwd_en_q && fwd_addr_q == rd_addr_q) begin
			rd_data = fwd_data_q;
		end else if (valid_q[rd_addr_q]) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

FILE: design/text_word_sentence_char_stats.sv
// Top level: word, sentence and character histogram statistics over a byte stream.
//
// Input channel (in_valid/in_stall) carries cmd, data_byte and bin_index.
// cmd FEED classifies one text byte, counts word and sentence starts and
// bumps the letter or digit bin of the byte; READ returns one bin; CLEAR
// zeroes all counts. Every item gives exactly one result on the output
// channel (out_valid/out_stall): word_count, sentence_count, bin_count.
// A result is registered after its input transfer: the transfer
// launches the synchronous bin memory read, and the following advance
// of the second stage registers the update and the result.
// Throughput is one item per cycle while out_stall is low; the read-modify-write of a bin closes
// in the second stage and a one-entry write forward covers back-to-back
// hits on the same bin.
// Reset clears all counts at once through per-bin valid bits; no sweep.
// When out_stall holds a result, the second stage can still fill, so one
// more item is taken before in_stall rises. Counters saturate at
// 2^COUNT_WIDTH - 1 and are shown in the low 32 bits of each result.
module text_word_sentence_char_stats import twscs_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [7:0]        data_byte,
	input  logic [BIN_W-1:0]  bin_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  word_count,
	output logic [OUT_W-1:0]  sentence_count,
	output logic [OUT_W-1:0]  bin_count
);

	localparam int EXT_W = COUNT_WIDTH + OUT_W;

	logic                   in_xfer;
	logic                   adv_s1;
	bin_sel_t               sel;
	logic                   valid_s1;
	logic [1:0]             cmd_s1;
	logic [7:0]             byte_s1;
	logic                   hit_s1;
	logic [BIN_W-1:0]       addr_s1;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] bin_inc;
	logic                   is_feed;
	logic                   is_sep;
	logic                   word_start;
	logic                   wr_en;
	logic                   clr;
	logic [COUNT_WIDTH-1:0] words_q;
	logic [COUNT_WIDTH-1:0] sentences_q;
	logic                   between_q;
	logic                   after_end_q;
	logic [COUNT_WIDTH-1:0] words_nxt;
	logic [COUNT_WIDTH-1:0] sentences_nxt;
	logic                   between_nxt;
	logic                   after_end_nxt;
	logic [COUNT_WIDTH-1:0] bin_val;
	logic [EXT_W-1:0]       words_ext;
	logic [EXT_W-1:0]       sentences_ext;
	logic [EXT_W-1:0]       bin_ext;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       word_count_q;
	logic [OUT_W-1:0]       sentence_count_q;
	logic [OUT_W-1:0]       bin_count_q;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		unique case (cmd)
			CMD_FEED: sel = bin_of(data_byte);
			CMD_READ: sel = bin_at(bin_index);
			default:  sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
			hit_s1  <= sel.hit;
			addr_s1 <= sel.idx;
		end
	end

	twscs_bin_ram #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_bin_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_xfer && sel.hit),
		.rd_addr(sel.idx),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(bin_inc),
		.clr    (clr),
		.rd_data(rd_data)
	);

	assign is_feed    = (cmd_s1 == CMD_FEED);
	assign is_sep     = is_separator(byte_s1);
	assign word_start = is_feed && !is_sep && between_q;
	assign bin_inc    = sat_inc(rd_data);
	assign wr_en      = valid_s1 && adv_s1 && is_feed && hit_s1;
	assign clr        = valid_s1 && adv_s1 && (cmd_s1 == CMD_CLEAR);

	always_comb begin
		words_nxt     = words_q;
		sentences_nxt = sentences_q;
		between_nxt   = between_q;
		after_end_nxt = after_end_q;
		bin_val       = '0;
		unique case (cmd_s1)
			CMD_FEED: begin
				if (is_sep) begin
					between_nxt = 1'b1;
					if (is_sentence_end(byte_s1)) begin
						after_end_nxt = 1'b1;
					end
				end else begin
					if (word_start) begin
						words_nxt = sat_inc(words_q);
						if (after_end_q) begin
							sentences_nxt = sat_inc(sentences_q);
						end
						between_nxt   = 1'b0;
						after_end_nxt = 1'b0;
					end
					if (hit_s1) begin
						bin_val = bin_inc;
					end
				end
			end
			CMD_READ: begin
				if (hit_s1) begin
					bin_val = rd_data;
				end
			end
			CMD_CLEAR: begin
				words_nxt     = '0;
				sentences_nxt = '0;
				between_nxt   = 1'b1;
				after_end_nxt = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q     <= '0;
			sentences_q <= '0;
			between_q   <= 1'b1;
			after_end_q <= 1'b1;
		end else if (valid_s1 && adv_s1) begin
			words_q     <= words_nxt;
			sentences_q <= sentences_nxt;
			between_q   <= between_nxt;
			after_end_q <= after_end_nxt;
		end
	end

	assign words_ext     = {{OUT_W{1'b0}}, words_nxt};
	assign sentences_ext = {{OUT_W{1'b0}}, sentences_nxt};
	assign bin_ext       = {{OUT_W{1'b0}}, bin_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			word_count_q     <= words_ext[OUT_W-1:0];
			sentence_count_q <= sentences_ext[OUT_W-1:0];
			bin_count_q      <= bin_ext[OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign word_count     = word_count_q;
	assign sentence_count = sentence_count_q;
	assign bin_count      = bin_count_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the text word, sentence and character histogram block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import twscs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [OUT_W-1:0] words;
		logic [OUT_W-1:0] sentences;
		logic [OUT_W-1:0] bin;
	} text_stats_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [1:0]       cmd       = CMD_FEED;
	logic [7:0]       data_byte = 8'h00;
	logic [BIN_W-1:0] bin_index = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [OUT_W-1:0] word_count;
	logic [OUT_W-1:0] sentence_count;
	logic [OUT_W-1:0] bin_count;

	logic [OUT_W-1:0] bin_tally [NUM_BINS];
	logic [OUT_W-1:0] word_total;
	logic [OUT_W-1:0] sentence_total;
	bit               in_gap;
	bit               saw_stop;
	text_stats_t      pending_stats [$];
	text_stats_t      oldest_stats;

	bit idle_on = 1'b0;
	int stall_left = 0;
	int errors = 0;
	int cycles = 0;
	int transfers_in = 0;
	int results_checked = 0;
	int clears_sent = 0;
	int reads_sent = 0;

	text_word_sentence_char_stats uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.bin_index     (bin_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.word_count    (word_count),
		.sentence_count(sentence_count),
		.bin_count     (bin_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_gap_byte(input logic [7:0] b);
		return (b >= 8'd32 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
			(b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126) || (b == 8'd10);
	endfunction

	function automatic int bin_for_byte(input logic [7:0] b);
		if (b >= "A" && b <= "Z") return int'(b - "A");
		if (b >= "a" && b <= "z") return int'(b - "a");
		if (b >= "0" && b <= "9") return LETTER_BINS + int'(b - "0");
		return -1;
	endfunction

	function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void clear_tallies();
		foreach (bin_tally[k]) bin_tally[k] = '0;
		word_total     = '0;
		sentence_total = '0;
		in_gap         = 1'b1;
		saw_stop       = 1'b1;
	endfunction

	task automatic tally_text_item(input logic [1:0] c, input logic [7:0] b,
			input logic [BIN_W-1:0] i);
		text_stats_t res;
		int slot;
		res.bin = '0;
		case (c)
			CMD_FEED: begin
				if (is_gap_byte(b)) begin
					in_gap = 1'b1;
					if (b == CH_BANG || b == CH_DOT || b == CH_QUERY) saw_stop = 1'b1;
				end else begin
					if (in_gap) begin
						word_total = bump(word_total);
						if (saw_stop) sentence_total = bump(sentence_total);
						in_gap   = 1'b0;
						saw_stop = 1'b0;
					end
					slot = bin_for_byte(b);
					if (slot >= 0) begin
						bin_tally[slot] = bump(bin_tally[slot]);
						res.bin = bin_tally[slot];
					end
				end
			end
			CMD_READ: begin
				if (i < NUM_BINS) res.bin = bin_tally[i];
			end
			CMD_CLEAR: begin
				clear_tallies();
			end
			default: begin
			end
		endcase
		res.words     = word_total;
		res.sentences = sentence_total;
		pending_stats.push_back(res);
	endtask

	task automatic send_item(input logic [1:0] c, input logic [7:0] b,
			input logic [BIN_W-1:0] i);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		data_byte <= b;
		bin_index <= i;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tally_text_item(c, b, i);
		transfers_in++;
		if (c == CMD_CLEAR) clears_sent++;
		if (c == CMD_READ) reads_sent++;
	endtask

	task automatic feed(input logic [7:0] b);
		send_item(CMD_FEED, b, BIN_W'($urandom_range(0, 63)));
	endtask

	task automatic test_byte_classes();
		feed("A"); feed("Z"); feed("a"); feed("z"); feed("0"); feed("9");
		feed(8'd0); feed(8'd255); feed(8'd9);
		feed(8'd10); feed(8'd32); feed(8'd47); feed(8'd58); feed(8'd64);
		feed(8'd91); feed(8'd96); feed(8'd123); feed(8'd126);
		feed("q"); feed(CH_DOT); feed("b"); feed(CH_BANG); feed(CH_QUERY); feed("1");
	endtask

	task automatic test_bin_reads();
		send_item(CMD_READ, 8'hFF, BIN_W'(0));
		send_item(CMD_READ, 8'h00, BIN_W'(NUM_BINS - 1));
		send_item(CMD_READ, 8'hAA, BIN_W'(NUM_BINS));
		send_item(CMD_READ, 8'h55, '1);
	endtask

	task automatic test_clear_and_unused();
		send_item(CMD_UNUSED, "x", BIN_W'(3));
		send_item(CMD_CLEAR, "y", BIN_W'(5));
		feed("M");
		send_item(CMD_READ, 8'h00, BIN_W'(12));
	endtask

	task automatic send_word();
		int len;
		int r;
		logic [7:0] b;
		len = $urandom_range(1, 8);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 40) b = 8'($urandom_range("a", "z"));
			else if (r < 70) b = 8'($urandom_range("A", "Z"));
			else if (r < 90) b = 8'($urandom_range("0", "9"));
			else begin
				do b = 8'($urandom_range(0, 255)); while (is_gap_byte(b) || bin_for_byte(b) >= 0);
			end
			feed(b);
		end
	endtask

	task automatic send_separators();
		int len;
		int r;
		logic [7:0] b;
		len = $urandom_range(1, 3);
		repeat (len) begin
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2: b = " ";
				3:       b = 8'd10;
				4:       b = ",";
				5:       b = CH_DOT;
				6:       b = CH_BANG;
				7:       b = CH_QUERY;
				default: begin
					do b = 8'($urandom_range(0, 255)); while (!is_gap_byte(b));
				end
			endcase
			feed(b);
		end
	endtask

	task automatic test_random_text(input int n_items);
		int stop_at;
		int r;
		stop_at = transfers_in + n_items;
		while (transfers_in < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) send_word();
			else if (r < 82) send_separators();
			else if (r < 92) send_item(CMD_READ, 8'($urandom), BIN_W'($urandom_range(0, NUM_BINS - 1)));
			else if (r < 97)
				send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					BIN_W'($urandom_range(0, 63)));
			else if (r < 99) send_item(CMD_UNUSED, 8'($urandom), BIN_W'($urandom));
			else send_item(CMD_CLEAR, 8'($urandom), BIN_W'($urandom));
		end
	endtask

	task automatic test_random_noise(input int n_items);
		repeat (n_items)
			send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				BIN_W'($urandom_range(0, 63)));
	endtask

	task automatic test_back_to_back(input int n_items);
		idle_on = 1'b0;
		test_random_text(n_items);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) stall_left--;
			else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
			out_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result words %0d sentences %0d bin %0d", $time,
					word_count, sentence_count, bin_count);
				errors++;
			end else begin
				oldest_stats = pending_stats.pop_front();
				results_checked++;
				if (word_count !== oldest_stats.words) begin
					$display("%0t: word_count expected %0d got %0d", $time,
						oldest_stats.words, word_count);
					errors++;
				end
				if (sentence_count !== oldest_stats.sentences) begin
					$display("%0t: sentence_count expected %0d got %0d", $time,
						oldest_stats.sentences, sentence_count);
					errors++;
				end
				if (bin_count !== oldest_stats.bin) begin
					$display("%0t: bin_count expected %0d got %0d", $time,
						oldest_stats.bin, bin_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_stats.size());
			$display("text_word_sentence_char_stats regression: fail");
			$finish;
		end
	end

	initial begin
		clear_tallies();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_byte_classes();
		test_bin_reads();
		test_clear_and_unused();
		test_random_text(540);
		test_random_noise(100);
		test_back_to_back(80);
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d transfers (%0d bin reads, %0d clears), checked %0d results.",
			transfers_in, reads_sent, clears_sent, results_checked);
		$display("Directed byte classes, random text with stalls, noise, and an unpaced tail.");
		if (errors == 0) begin
			$display("text_word_sentence_char_stats regression: pass");
		end else begin
			$display("text_word_sentence_char_stats regression: fail");
		end
		$finish;
	end

endmodule
